// ===== src/soa_pkg.sv =====
// shared types and constants of the slab object allocator
package soa_pkg;

   localparam int MAX_SLABS   = 16;
   localparam int MAX_OBJECTS = 64;
   localparam int SLAB_W      = 4;
   localparam int OBJ_W       = 6;
   localparam int ADDR_W      = SLAB_W + OBJ_W;
   localparam int MEM_DEPTH   = MAX_SLABS * MAX_OBJECTS;

   // free-list link, with the end mark at MAX_OBJECTS
   localparam logic [OBJ_W:0]  OBJ_END  = 7'(MAX_OBJECTS);
   // slab list link, with the null link at MAX_SLABS
   localparam logic [SLAB_W:0] SLAB_NIL = 5'(MAX_SLABS);

   // result codes
   localparam logic [1:0] ST_ALLOC    = 2'd0;
   localparam logic [1:0] ST_FREED    = 2'd1;
   localparam logic [1:0] ST_NO_SLOT  = 2'd2;
   localparam logic [1:0] ST_BAD_FREE = 2'd3;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // one object entry: allocated flag and free-list link
   typedef struct packed {
      logic             taken;
      logic [OBJ_W:0]   link;
   } obj_entry_type;

   // access to the object memory
   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_W-1:0]    wr_addr;
      obj_entry_type        wr_data;
      logic [ADDR_W-1:0]    rd_addr;
   } obj_mem_ctl_type;

endpackage

// ===== src/soa_ifs.sv =====
// request and response channel interfaces
interface soa_req_if;
   import soa_pkg::*;
   logic              valid;
   logic              ready;
   logic              action;
   logic [SLAB_W-1:0] slab_id;
   logic [OBJ_W-1:0]  object_index;
   modport source (output valid, action, slab_id, object_index, input ready);
   modport sink   (input valid, action, slab_id, object_index, output ready);
endinterface

interface soa_rsp_if;
   import soa_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic              grown;
   logic [SLAB_W-1:0] out_slab;
   logic [OBJ_W-1:0]  out_object;
   modport source (output valid, status, grown, out_slab, out_object, input ready);
   modport sink   (input valid, status, grown, out_slab, out_object, output ready);
endinterface

// ===== src/slab_object_allocator.sv =====
// slab cache allocator top level
// One request is handled at a time. An allocate from an existing slab goes
// through accept with memory read, read-modify-write of the object entry,
// result staging (waits while an earlier result is unaccepted) and the result
// register. Growing a slab first writes one object link per cycle into the
// object memory. A free goes through accept with memory read, entry check,
// and, when the slab moves in the slab list, unlink, insert and a first-not-full
// fixup where needed, then result staging and the result register. The object
// memory needs no clearing pass: its entries are written when a slab is grown, before any read.
module slab_object_allocator
   import soa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [6:0] csr_wdata,
   soa_req_if.sink    req_if,
   soa_rsp_if.source  rsp_if
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_GROW   = 4'd1;
   localparam logic [3:0] S_AREAD  = 4'd2;
   localparam logic [3:0] S_ACHK   = 4'd3;
   localparam logic [3:0] S_FCHK   = 4'd4;
   localparam logic [3:0] S_UNLINK = 4'd5;
   localparam logic [3:0] S_INSERT = 4'd6;
   localparam logic [3:0] S_FIXUP  = 4'd7;
   localparam logic [3:0] S_POST   = 4'd8;

   logic [3:0]        state_ff;
   logic [6:0]        cfg_ff;
   logic [OBJ_W:0]    head_ff   [MAX_SLABS];
   logic [OBJ_W:0]    in_use_ff [MAX_SLABS];
   logic [OBJ_W:0]    size_ff   [MAX_SLABS];
   logic [SLAB_W:0]   prev_ff   [MAX_SLABS];
   logic [SLAB_W:0]   next_ff   [MAX_SLABS];
   logic [SLAB_W:0]   first_ff, last_ff, fnf_ff, created_ff;
   logic [SLAB_W-1:0] slab_ff;
   logic [OBJ_W-1:0]  obj_ff;
   logic [OBJ_W:0]    grow_idx_ff;
   logic              grown_ff;
   logic [SLAB_W:0]   tgt_ff, t0_ff;
   logic              fix_ff;
   logic [1:0]        res_status_ff;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic              rsp_grown_ff;
   logic [SLAB_W-1:0] rsp_slab_ff;
   logic [OBJ_W-1:0]  rsp_obj_ff;

   obj_mem_ctl_type   mem_ctl;
   obj_entry_type     mem_rd;
   logic [OBJ_W:0]    eff_n;
   logic [OBJ_W:0]    grow_nxt;
   logic              req_xfer;
   logic [SLAB_W:0]   ins_p;
   logic [SLAB_W:0]   ul_p, ul_n;

   soa_obj_mem u_obj_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .rd_data (mem_rd)
   );

   // objects per new slab, clamped to 1..MAX_OBJECTS
   always_comb begin
      if (cfg_ff == 7'd0) begin
         eff_n = 7'd1;
      end else if (cfg_ff > 7'(MAX_OBJECTS)) begin
         eff_n = 7'(MAX_OBJECTS);
      end else begin
         eff_n = cfg_ff;
      end
   end

   assign grow_nxt = grow_idx_ff + 7'd1;
   assign req_xfer = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == S_IDLE);

   assign ul_p  = prev_ff[slab_ff];
   assign ul_n  = next_ff[slab_ff];
   assign ins_p = tgt_ff[SLAB_W] ? last_ff : prev_ff[tgt_ff[SLAB_W-1:0]];

   // object memory access
   always_comb begin
      mem_ctl = '0;
      mem_ctl.rd_addr = {fnf_ff[SLAB_W-1:0], head_ff[fnf_ff[SLAB_W-1:0]][OBJ_W-1:0]};
      case (state_ff)
         S_IDLE: begin
            if (req_if.action == ACT_FREE) begin
               mem_ctl.rd_addr = {req_if.slab_id, req_if.object_index};
            end
         end
         S_GROW: begin
            mem_ctl.wr_en         = 1'b1;
            mem_ctl.wr_addr       = {slab_ff, grow_idx_ff[OBJ_W-1:0]};
            mem_ctl.wr_data.taken = 1'b0;
            mem_ctl.wr_data.link  = (grow_nxt < eff_n) ? grow_nxt : OBJ_END;
         end
         S_AREAD: begin
            mem_ctl.rd_addr = {slab_ff, {OBJ_W{1'b0}}};
         end
         S_ACHK: begin
            mem_ctl.wr_en         = 1'b1;
            mem_ctl.wr_addr       = {slab_ff, obj_ff};
            mem_ctl.wr_data.taken = 1'b1;
            mem_ctl.wr_data.link  = mem_rd.link;
         end
         S_FCHK: begin
            mem_ctl.wr_en         = mem_rd.taken;
            mem_ctl.wr_addr       = {slab_ff, obj_ff};
            mem_ctl.wr_data.taken = 1'b0;
            mem_ctl.wr_data.link  = head_ff[slab_ff];
         end
         default: begin
         end
      endcase
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= 7'd8;
      end else if (csr_we) begin
         cfg_ff <= csr_wdata;
      end
   end

   // sequencer and slab tables
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         first_ff   <= SLAB_NIL;
         last_ff    <= SLAB_NIL;
         fnf_ff     <= SLAB_NIL;
         created_ff <= '0;
         for (int i = 0; i < MAX_SLABS; i++) begin
            in_use_ff[i] <= '0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  grown_ff <= 1'b0;
                  if (req_if.action == ACT_ALLOC) begin
                     if (fnf_ff[SLAB_W]) begin
                        if (created_ff[SLAB_W]) begin
                           res_status_ff <= ST_NO_SLOT;
                           state_ff      <= S_POST;
                        end else begin
                           slab_ff     <= created_ff[SLAB_W-1:0];
                           grow_idx_ff <= '0;
                           state_ff    <= S_GROW;
                        end
                     end else if (head_ff[fnf_ff[SLAB_W-1:0]][OBJ_W]) begin
                        res_status_ff <= ST_NO_SLOT;
                        state_ff      <= S_POST;
                     end else begin
                        slab_ff  <= fnf_ff[SLAB_W-1:0];
                        obj_ff   <= head_ff[fnf_ff[SLAB_W-1:0]][OBJ_W-1:0];
                        state_ff <= S_ACHK;
                     end
                  end else begin
                     slab_ff <= req_if.slab_id;
                     obj_ff  <= req_if.object_index;
                     // unknown slab or object past the end of its slab
                     if ({1'b0, req_if.slab_id} >= created_ff ||
                         {1'b0, req_if.object_index} >= size_ff[req_if.slab_id]) begin
                        res_status_ff <= ST_BAD_FREE;
                        state_ff      <= S_POST;
                     end else begin
                        state_ff <= S_FCHK;
                     end
                  end
               end
            end
            S_GROW: begin
               grow_idx_ff <= grow_nxt;
               if (grow_nxt >= eff_n) begin
                  // slab ready: append at the tail as first-not-full
                  head_ff[slab_ff]   <= '0;
                  in_use_ff[slab_ff] <= '0;
                  size_ff[slab_ff]   <= eff_n;
                  created_ff         <= created_ff + 5'd1;
                  fnf_ff             <= {1'b0, slab_ff};
                  grown_ff           <= 1'b1;
                  prev_ff[slab_ff]   <= last_ff;
                  next_ff[slab_ff]   <= SLAB_NIL;
                  if (last_ff[SLAB_W]) begin
                     first_ff <= {1'b0, slab_ff};
                  end else begin
                     next_ff[last_ff[SLAB_W-1:0]] <= {1'b0, slab_ff};
                  end
                  last_ff  <= {1'b0, slab_ff};
                  state_ff <= S_AREAD;
               end
            end
            S_AREAD: begin
               obj_ff   <= '0;
               state_ff <= S_ACHK;
            end
            S_ACHK: begin
               head_ff[slab_ff]   <= mem_rd.link;
               in_use_ff[slab_ff] <= in_use_ff[slab_ff] + 7'd1;
               if (mem_rd.link[OBJ_W]) begin
                  fnf_ff <= next_ff[slab_ff];
               end
               res_status_ff <= ST_ALLOC;
               state_ff      <= S_POST;
            end
            S_FCHK: begin
               if (!mem_rd.taken) begin
                  res_status_ff <= ST_BAD_FREE;
                  state_ff      <= S_POST;
               end else begin
                  res_status_ff    <= ST_FREED;
                  head_ff[slab_ff] <= {1'b0, obj_ff};
                  if (in_use_ff[slab_ff] != '0) begin
                     in_use_ff[slab_ff] <= in_use_ff[slab_ff] - 7'd1;
                  end
                  if (head_ff[slab_ff][OBJ_W]) begin
                     // formerly full: move before first-not-full
                     fnf_ff   <= {1'b0, slab_ff};
                     tgt_ff   <= fnf_ff;
                     fix_ff   <= 1'b0;
                     state_ff <= (next_ff[slab_ff] != fnf_ff) ? S_UNLINK : S_POST;
                  end else if (in_use_ff[slab_ff] <= 7'd1) begin
                     // now empty: move to the tail
                     t0_ff    <= fnf_ff[SLAB_W] ? last_ff : prev_ff[fnf_ff[SLAB_W-1:0]];
                     tgt_ff   <= SLAB_NIL;
                     fix_ff   <= (fnf_ff == {1'b0, slab_ff});
                     state_ff <= S_UNLINK;
                  end else begin
                     state_ff <= S_POST;
                  end
               end
            end
            S_UNLINK: begin
               if (ul_p[SLAB_W]) begin
                  first_ff <= ul_n;
               end else begin
                  next_ff[ul_p[SLAB_W-1:0]] <= ul_n;
               end
               if (ul_n[SLAB_W]) begin
                  last_ff <= ul_p;
               end else begin
                  prev_ff[ul_n[SLAB_W-1:0]] <= ul_p;
               end
               state_ff <= S_INSERT;
            end
            S_INSERT: begin
               prev_ff[slab_ff] <= ins_p;
               next_ff[slab_ff] <= tgt_ff;
               if (ins_p[SLAB_W]) begin
                  first_ff <= {1'b0, slab_ff};
               end else begin
                  next_ff[ins_p[SLAB_W-1:0]] <= {1'b0, slab_ff};
               end
               if (tgt_ff[SLAB_W]) begin
                  last_ff <= {1'b0, slab_ff};
               end else begin
                  prev_ff[tgt_ff[SLAB_W-1:0]] <= {1'b0, slab_ff};
               end
               state_ff <= fix_ff ? S_FIXUP : S_POST;
            end
            S_FIXUP: begin
               fnf_ff   <= t0_ff[SLAB_W] ? first_ff : next_ff[t0_ff[SLAB_W-1:0]];
               state_ff <= S_POST;
            end
            S_POST: begin
               if (!rsp_valid_ff || rsp_if.ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_POST && (!rsp_valid_ff || rsp_if.ready)) begin
         rsp_valid_ff  <= 1'b1;
         rsp_status_ff <= res_status_ff;
         if (res_status_ff == ST_ALLOC) begin
            rsp_grown_ff <= grown_ff;
            rsp_slab_ff  <= slab_ff;
            rsp_obj_ff   <= obj_ff;
         end else begin
            rsp_grown_ff <= 1'b0;
            rsp_slab_ff  <= '0;
            rsp_obj_ff   <= '0;
         end
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.grown      = rsp_grown_ff;
   assign rsp_if.out_slab   = rsp_slab_ff;
   assign rsp_if.out_object = rsp_obj_ff;

   // checks
   a_created_bound: assert property (@(posedge clock) disable iff (reset)
      created_ff <= 5'(MAX_SLABS))
      else $error("slab count beyond the slot limit");

   a_grown_alloc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_grown_ff |-> rsp_status_ff == ST_ALLOC)
      else $error("grown flag on a result that is no allocation");

   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff != S_IDLE)
      else $error("sequencer idle right after a request transfer");

   a_grow_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GROW |-> grow_idx_ff < eff_n)
      else $error("slab growth index past the object count");

endmodule

// ===== src/soa_obj_mem.sv =====
// object memory: free-list links and allocated flags, registered read
module soa_obj_mem
   import soa_pkg::*;
(
   input  logic            clock,
   input  obj_mem_ctl_type ctl,
   output obj_entry_type   rd_data
);

   obj_entry_type mem [MEM_DEPTH];
   obj_entry_type rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      rd_data_ff <= mem[ctl.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
